FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the line editor rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define CLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLE_ASSERT(lbl, clk, rst_n, prop)
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/cle_pkg.sv
// shared types and constants of the console line editor
// no dependencies
package cle_pkg;

  // line store geometry
  localparam int LINE_LEN = 32;
  localparam int ADDR_W   = $clog2(LINE_LEN);
  localparam int BYTE_W   = 8;
  localparam int CHAR_W   = 7;

  // 7-bit character codes
  localparam logic [CHAR_W-1:0] CH_NL   = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_CR   = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_BS   = 7'h08;
  localparam logic [CHAR_W-1:0] CH_DEL  = 7'h7F;
  localparam logic [CHAR_W-1:0] CH_HASH = 7'h23;
  localparam logic [CHAR_W-1:0] CH_AT   = 7'h40;
  localparam logic [CHAR_W-1:0] CH_XON  = 7'h11;
  localparam logic [CHAR_W-1:0] CH_XOFF = 7'h13;
  localparam logic [CHAR_W-1:0] CH_KILL = 7'h15;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // source of the next result loaded into the output register
  typedef enum logic [1:0] {
    SEL_ECHO = 2'd0,
    SEL_NL   = 2'd1,
    SEL_LINE = 2'd2,
    SEL_NUL  = 2'd3
  } out_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     cap_in;
    logic     load_out;
    out_sel_t out_sel;
    logic     echo_last;
    logic     fill_upd;
    logic     clr_fill;
    logic     rd_clr;
    logic     rd_issue;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_eol;
    logic is_kill;
    logic rd_more;
    logic slot_free;
    logic out_valid;
    logic out_last;
  } sts_t;

endpackage

FILE: hw/rtl/cle_if.sv
// valid/ready channel interfaces of the console line editor
// depends on cle_pkg for field widths

// received byte channel
interface cle_in_if;
  logic                        valid;
  logic                        ready;
  logic [cle_pkg::BYTE_W-1:0]  rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface cle_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [cle_pkg::BYTE_W-1:0]  data;
  logic                        last;
  modport source (output valid, output kind, output data, output last, input ready);
  modport sink (input valid, input kind, input data, input last, output ready);
endinterface

// mode register write channel
interface cle_cfg_if;
  logic valid;
  logic ready;
  logic strip_to_seven_bits;
  modport source (output valid, output strip_to_seven_bits, input ready);
  modport sink (input valid, input strip_to_seven_bits, output ready);
endinterface

FILE: hw/rtl/console_line_editor.sv
// console line editor: echo of received bytes with erase, kill and line readout
// top level; depends on cle_pkg, cle_if, cle_ctrl and cle_dp
// the received byte goes through the char register; its echo is then loaded into the output register
// no new byte is accepted until the editor is back in idle, after the echo, kill newline or readout
// the end-of-line readout uses one line store read port; each char is read, then loaded for output
// reset: fill count 0, seven-bit stripping on, line store contents undefined
module console_line_editor (
  input logic           clk,
  input logic           rst_n,
  cle_in_if.sink        in_bus,
  cle_out_if.source     out_bus,
  cle_cfg_if.sink       cfg_bus
);

  cle_pkg::cmd_t cmd;
  cle_pkg::sts_t sts;

  // config writes are always taken
  assign cfg_bus.ready = 1'b1;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .rx_byte   (in_bus.rx_byte),
    .cfg_we    (cfg_bus.valid),
    .cfg_strip (cfg_bus.strip_to_seven_bits),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_kind  (out_bus.kind),
    .out_data  (out_bus.data),
    .out_last  (out_bus.last)
  );

endmodule

FILE: hw/rtl/cle_dp.sv
// datapath of the console line editor: mode register, char register,
// line store memory, fill count, read pointer and output register; uses cle_pkg
`include "assert_macros.svh"
module cle_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cle_pkg::cmd_t              cmd,
  output cle_pkg::sts_t              sts,
  input  logic [cle_pkg::BYTE_W-1:0] rx_byte,
  input  logic                       cfg_we,
  input  logic                       cfg_strip,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kind,
  output logic [cle_pkg::BYTE_W-1:0] out_data,
  output logic                       out_last
);

  localparam logic [cle_pkg::ADDR_W-1:0] FILL_MAX = cle_pkg::ADDR_W'(cle_pkg::LINE_LEN - 1);

  logic                        strip_r;
  logic [cle_pkg::BYTE_W-1:0]  char_r;
  logic [cle_pkg::BYTE_W-1:0]  char_nxt;
  logic [cle_pkg::ADDR_W-1:0]  fill_r;
  logic [cle_pkg::ADDR_W-1:0]  fill_nxt;
  logic [cle_pkg::ADDR_W-1:0]  rd_idx_r;
  logic [cle_pkg::CHAR_W-1:0]  rd_data_r;
  logic [cle_pkg::CHAR_W-1:0]  line_mem [cle_pkg::LINE_LEN];
  logic                        out_valid_r;
  logic                        out_kind_r;
  logic [cle_pkg::BYTE_W-1:0]  out_data_r;
  logic                        out_last_r;
  logic [cle_pkg::CHAR_W-1:0]  e;
  logic                        is_eol;
  logic                        is_kill;
  logic                        is_flow;
  logic                        is_erase;
  logic                        do_store;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= 1'b1;
    end else if (cfg_we) begin
      strip_r <= cfg_strip;
    end
  end

  // input char: optional strip, carriage return becomes newline
  always_comb begin
    char_nxt = strip_r ? {1'b0, rx_byte[cle_pkg::CHAR_W-1:0]} : rx_byte;
    if (char_nxt == {1'b0, cle_pkg::CH_CR}) begin
      char_nxt = {1'b0, cle_pkg::CH_NL};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      char_r <= char_nxt;
    end
  end

  // classify the 7-bit editing char
  assign e        = char_r[cle_pkg::CHAR_W-1:0];
  assign is_eol   = (e == cle_pkg::CH_NL) || (e == cle_pkg::CH_CR);
  assign is_kill  = (e == cle_pkg::CH_AT) || (e == cle_pkg::CH_KILL);
  assign is_flow  = (e == cle_pkg::CH_XON) || (e == cle_pkg::CH_XOFF);
  assign is_erase = (e == cle_pkg::CH_BS) || (e == cle_pkg::CH_HASH) ||
                    (e == cle_pkg::CH_DEL);
  assign do_store = cmd.fill_upd && !is_eol && !is_kill && !is_flow && !is_erase &&
                    (fill_r < FILL_MAX);

  // fill count: append, erase, clear
  always_comb begin
    fill_nxt = fill_r;
    priority if (cmd.clr_fill) begin
      fill_nxt = '0;
    end else if (do_store) begin
      fill_nxt = fill_r + cle_pkg::ADDR_W'(1);
    end else if (cmd.fill_upd && is_erase && (fill_r != '0)) begin
      fill_nxt = fill_r - cle_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // line store write port
  always_ff @(posedge clk) begin
    if (do_store) begin
      line_mem[fill_r] <= e;
    end
  end

  // line store read port with registered data
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= line_mem[rd_idx_r];
    end
  end

  // readout pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_clr) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_issue) begin
      rd_idx_r <= rd_idx_r + cle_pkg::ADDR_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      unique case (cmd.out_sel)
        cle_pkg::SEL_ECHO: begin
          out_kind_r <= cle_pkg::KIND_ECHO;
          out_data_r <= char_r;
          out_last_r <= cmd.echo_last;
        end
        cle_pkg::SEL_NL: begin
          out_kind_r <= cle_pkg::KIND_ECHO;
          out_data_r <= {1'b0, cle_pkg::CH_NL};
          out_last_r <= 1'b1;
        end
        cle_pkg::SEL_LINE: begin
          out_kind_r <= cle_pkg::KIND_LINE;
          out_data_r <= {1'b0, rd_data_r};
          out_last_r <= 1'b0;
        end
        default: begin
          out_kind_r <= cle_pkg::KIND_LINE;
          out_data_r <= '0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // status
  assign sts.is_eol    = is_eol;
  assign sts.is_kill   = is_kill;
  assign sts.rd_more   = rd_idx_r < fill_r;
  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.out_valid = out_valid_r;
  assign sts.out_last  = out_last_r;

  // checks
  `CLE_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_MAX)
  `CLE_ASSERT(a_rd_in_line, clk, rst_n, !cmd.rd_issue || (rd_idx_r < fill_r))
  `CLE_ASSERT(a_load_free, clk, rst_n, !cmd.load_out || !out_valid_r || out_ready)

endmodule

FILE: hw/rtl/cle_ctrl.sv
// controller state machine of the console line editor
// sequences echo, kill newline and line readout; uses cle_pkg types
`include "assert_macros.svh"
module cle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cle_pkg::sts_t sts,
  output cle_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ECHO = 6'b000010,
    ST_KILL = 6'b000100,
    ST_READ = 6'b001000,
    ST_LINE = 6'b010000,
    ST_NUL  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.out_sel   = cle_pkg::SEL_ECHO;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.cap_in = 1'b1;
          cmd.rd_clr = 1'b1;
          state_nxt  = ST_ECHO;
        end
      end
      ST_ECHO: begin
        if (sts.slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_sel   = cle_pkg::SEL_ECHO;
          cmd.echo_last = !sts.is_eol && !sts.is_kill;
          cmd.fill_upd  = 1'b1;
          priority if (sts.is_eol) begin
            state_nxt = ST_READ;
          end else if (sts.is_kill) begin
            state_nxt = ST_KILL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_KILL: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_NL;
          cmd.clr_fill = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.rd_more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_LINE;
        end else begin
          state_nxt = ST_NUL;
        end
      end
      ST_LINE: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_LINE;
          state_nxt    = ST_READ;
        end
      end
      ST_NUL: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = cle_pkg::SEL_NUL;
          cmd.clr_fill = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `CLE_ASSERT_NEXT(a_accept_echo, clk, rst_n, in_fire, state_r == ST_ECHO)
  `CLE_ASSERT_NEXT(a_read_line, clk, rst_n, (state_r == ST_READ) && sts.rd_more,
                   state_r == ST_LINE)
  `CLE_ASSERT(a_idle_last, clk, rst_n, !((state_r == ST_IDLE) && sts.out_valid) || sts.out_last)

endmodule
